### rtl/mml_pkg.sv
// Package for the music macro text parser: constants, codes, link types and
// the pitch lookup used by the sequencer.
// Depends on nothing.
`default_nettype none

package mml_pkg;

    // Number of octaves the text may address.
    localparam int OCTAVES = 7;
    localparam int OCT_W = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
    localparam logic [OCT_W-1:0] OCT_MAX = OCT_W'(OCTAVES - 1);
    localparam logic [OCT_W-1:0] OCT_RESET = (OCTAVES > 2) ? OCT_W'(2) : OCT_W'(OCTAVES - 1);
    localparam logic [6:0] NOTE_MAX = 7'(12 * OCTAVES - 1);

    // Field widths.
    localparam int NUM_W = 16;
    localparam int PITCH_W = 22;

    // Register reset values.
    localparam logic [15:0] BEAT_MS_RESET = 16'd600;
    localparam logic [15:0] WARN_PAUSE_RESET = 16'd500;

    // Configuration register indexes.
    localparam logic [0:0] REG_BEAT_MS = 1'b0;
    localparam logic [0:0] REG_WARN_PAUSE = 1'b1;

    // Event kinds.
    localparam logic [1:0] EV_NOTE = 2'd0;
    localparam logic [1:0] EV_REST = 2'd1;
    localparam logic [1:0] EV_WARN = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LG = 8'h67;
    localparam logic [7:0] CH_UR = 8'h52;
    localparam logic [7:0] CH_LR = 8'h72;

    // Parse phase of the pending event.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_DETUNE = 3'b010,
        PH_DIGITS = 3'b100
    } parse_phase_t;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [NUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

    // Semitone offset of a note letter within its octave (a b c d e f g).
    function automatic logic [3:0] note_offset(input logic [2:0] letter);
        logic [3:0] off;
        case (letter)
            3'd0:    off = 4'd9;
            3'd1:    off = 4'd11;
            3'd2:    off = 4'd0;
            3'd3:    off = 4'd2;
            3'd4:    off = 4'd4;
            3'd5:    off = 4'd5;
            3'd6:    off = 4'd7;
            default: off = 4'd0;
        endcase
        return off;
    endfunction

    // Lowest octave frequencies in Hz, Q16.
    function automatic logic [22:0] base_q16(input logic [3:0] semi);
        logic [22:0] b;
        case (semi)
            4'd0:    b = 23'd4286054;
            4'd1:    b = 23'd4540917;
            4'd2:    b = 23'd4810933;
            4'd3:    b = 23'd5097006;
            4'd4:    b = 23'd5400090;
            4'd5:    b = 23'd5721196;
            4'd6:    b = 23'd6061396;
            4'd7:    b = 23'd6421826;
            4'd8:    b = 23'd6803688;
            4'd9:    b = 23'd7208255;
            4'd10:   b = 23'd7636881;
            4'd11:   b = 23'd8090993;
            default: b = 23'd0;
        endcase
        return b;
    endfunction

    // Pitch of a semitone index in Hz Q8, rounded and saturated.
    function automatic logic [PITCH_W-1:0] pitch_of(input logic [6:0] idx);
        int          oct;
        logic [6:0]  semi;
        logic [35:0] v;
        oct = 0;
        for (int k = 1; k < OCTAVES; k++) begin
            if (idx >= 7'(12 * k)) begin
                oct = k;
            end
        end
        semi = idx - 7'(12 * oct);
        v = ((36'(base_q16(semi[3:0])) << oct) + 36'd128) >> 8;
        if (v > 36'(22'h3FFFFF)) begin
            v = 36'(22'h3FFFFF);
        end
        return v[PITCH_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/mml_note_stream_parser.sv
// Top level of the music macro text parser: input decode, parse state,
// event sequencing and the output register.
// Depends on mml_pkg and mml_div.
`default_nettype none

// One text byte is taken per input beat. Bytes that only change the parse
// state (octave marks, detune signs, length digits, blanks) give no result
// and leave the input ready. A byte that closes a pending note or rest
// starts the shared 16-step divider for the duration; the event is offered
// once the divider is done, followed by a warning when the byte also gives
// one. A warning alone is offered in the cycle after the beat. The input is
// not ready after the accepting beat until the last result of that byte has
// been taken; the divider and the output handshake set the length of the
// busy window.
module mml_note_stream_parser
    import mml_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // Text input.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // text_end
    // Event output.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] note_index, [28:7] pitch_q8, [44:29] length_divider,
    // [60:45] duration_ms, [68:61] unknown_char, [71:69] zero
    output logic [71:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] event_kind
    output logic             m_tlast    // last_of_run
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SEND = 3'b100
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    parse_phase_t      phase_reg, phase_next;
    logic [OCT_W-1:0]  oct_reg, oct_next;
    logic              is_rest_reg, is_rest_next;
    logic [6:0]        note_reg, note_next;
    logic [NUM_W-1:0]  acc_reg, acc_next;
    logic              digits_reg, digits_next;
    logic              warn_pend_reg, warn_pend_next;
    logic [7:0]        warn_char_reg, warn_char_next;
    logic [15:0]       beat_ms_reg;
    logic [15:0]       warn_pause_reg;

    // Output payload.
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [6:0]        out_note_reg, out_note_next;
    logic [PITCH_W-1:0] out_pitch_reg, out_pitch_next;
    logic [NUM_W-1:0]  out_div_reg, out_div_next;
    logic [15:0]       out_dur_reg, out_dur_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic       accept;
    logic [7:0] ch;
    logic       is_digit, is_sign, is_blank, is_up, is_down;
    logic       is_upper_note, is_lower_note, is_rest_ch;
    logic [2:0] letter;
    logic [19:0] acc_mul;
    logic [NUM_W-1:0] flush_div;
    logic [6:0] new_note;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign ch       = s_tdata;

    // Character classes.
    assign is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sign       = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign is_blank      = (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_LF);
    assign is_up         = (ch == CH_GT);
    assign is_down       = (ch == CH_LT);
    assign is_upper_note = (ch >= CH_UA) && (ch <= CH_UG);
    assign is_lower_note = (ch >= CH_LA) && (ch <= CH_LG);
    assign is_rest_ch    = (ch == CH_UR) || (ch == CH_LR);
    assign letter        = is_upper_note ? 3'(ch - CH_UA) : 3'(ch - CH_LA);

    // Length digit accumulation: acc * 10 + digit.
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {16'd0, 4'(ch - CH_ZERO)};

    // Divider of the event being closed: 1 when absent or zero.
    assign flush_div = (!digits_reg || (acc_reg == '0)) ? NUM_W'(1) : acc_reg;

    // Note opened by a letter at the current octave.
    assign new_note = 7'({oct_reg, 3'b000}) + 7'({oct_reg, 2'b00})
                    + {3'b000, note_offset(letter)};

    // Parse and sequencing logic.
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        oct_next       = oct_reg;
        is_rest_next   = is_rest_reg;
        note_next      = note_reg;
        acc_next       = acc_reg;
        digits_next    = digits_reg;
        warn_pend_next = warn_pend_reg;
        warn_char_next = warn_char_reg;
        out_kind_next  = out_kind_reg;
        out_note_next  = out_note_reg;
        out_pitch_next = out_pitch_reg;
        out_div_next   = out_div_reg;
        out_dur_next   = out_dur_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        div_req.start    = 1'b0;
        div_req.dividend = beat_ms_reg;
        div_req.divisor  = flush_div;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_tlast && (phase_reg == PH_DETUNE) && is_sign) begin
                        // Detune the pending note.
                        if (ch == CH_PLUS) begin
                            if (note_reg < NOTE_MAX) begin
                                note_next = note_reg + 7'd1;
                            end
                        end else if (note_reg > 7'd0) begin
                            note_next = note_reg - 7'd1;
                        end
                    end else if (!s_tlast && (phase_reg != PH_IDLE) && is_digit) begin
                        // Extend the length number, saturating.
                        acc_next    = (acc_mul > 20'hFFFF) ? 16'hFFFF : acc_mul[15:0];
                        digits_next = 1'b1;
                        phase_next  = PH_DIGITS;
                    end else begin
                        // Close the pending event into the output register.
                        if (phase_reg != PH_IDLE) begin
                            out_kind_next  = is_rest_reg ? EV_REST : EV_NOTE;
                            out_note_next  = is_rest_reg ? 7'd0 : note_reg;
                            out_pitch_next = is_rest_reg ? '0 : pitch_of(note_reg);
                            out_div_next   = flush_div;
                            out_char_next  = 8'd0;
                            out_last_next  = 1'b1;
                            div_req.start  = 1'b1;
                            state_next     = ST_DIV;
                            phase_next     = PH_IDLE;
                            is_rest_next   = 1'b0;
                            note_next      = 7'd0;
                            acc_next       = '0;
                            digits_next    = 1'b0;
                        end
                        // Act on the byte itself.
                        if (!s_tlast) begin
                            if (is_blank) begin
                                // Skipped.
                            end else if (is_up) begin
                                if (oct_reg < OCT_MAX) begin
                                    oct_next = oct_reg + OCT_W'(1);
                                end
                            end else if (is_down) begin
                                if (oct_reg > '0) begin
                                    oct_next = oct_reg - OCT_W'(1);
                                end
                            end else if (is_upper_note || is_lower_note) begin
                                note_next    = new_note;
                                is_rest_next = 1'b0;
                                acc_next     = '0;
                                digits_next  = 1'b0;
                                phase_next   = PH_DETUNE;
                            end else if (is_rest_ch) begin
                                note_next    = 7'd0;
                                is_rest_next = 1'b1;
                                acc_next     = '0;
                                digits_next  = 1'b0;
                                phase_next   = PH_DIGITS;
                            end else if (phase_reg != PH_IDLE) begin
                                // Warning follows the closed event.
                                out_last_next  = 1'b0;
                                warn_pend_next = 1'b1;
                                warn_char_next = ch;
                            end else begin
                                // Warning alone.
                                out_kind_next  = EV_WARN;
                                out_note_next  = 7'd0;
                                out_pitch_next = '0;
                                out_div_next   = NUM_W'(1);
                                out_dur_next   = warn_pause_reg;
                                out_char_next  = ch;
                                out_last_next  = 1'b1;
                                state_next     = ST_SEND;
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    out_dur_next = div_rsp.quotient;
                    state_next   = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (warn_pend_reg) begin
                        out_kind_next  = EV_WARN;
                        out_note_next  = 7'd0;
                        out_pitch_next = '0;
                        out_div_next   = NUM_W'(1);
                        out_dur_next   = warn_pause_reg;
                        out_char_next  = warn_char_reg;
                        out_last_next  = 1'b1;
                        warn_pend_next = 1'b0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and parse state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            oct_reg       <= OCT_RESET;
            is_rest_reg   <= 1'b0;
            note_reg      <= 7'd0;
            acc_reg       <= '0;
            digits_reg    <= 1'b0;
            warn_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            oct_reg       <= oct_next;
            is_rest_reg   <= is_rest_next;
            note_reg      <= note_next;
            acc_reg       <= acc_next;
            digits_reg    <= digits_next;
            warn_pend_reg <= warn_pend_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_ms_reg    <= BEAT_MS_RESET;
            warn_pause_reg <= WARN_PAUSE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BEAT_MS:    beat_ms_reg    <= cfg_wdata;
                REG_WARN_PAUSE: warn_pause_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Output payload and held warning byte.
    always_ff @(posedge aclk) begin
        warn_char_reg <= warn_char_next;
        out_kind_reg  <= out_kind_next;
        out_note_reg  <= out_note_next;
        out_pitch_reg <= out_pitch_next;
        out_div_reg   <= out_div_next;
        out_dur_reg   <= out_dur_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    // Shared divider for event durations.
    mml_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tdata = {3'b000, out_char_reg, out_dur_reg, out_div_reg,
                      out_pitch_reg, out_note_reg};
    assign m_tuser = out_kind_reg;
    assign m_tlast = out_last_reg;

endmodule

`default_nettype wire

### rtl/mml_div.sv
// Shared restoring divider: one quotient bit per clock, 16 steps per divide.
// Depends on mml_pkg for the request and response types.
`default_nettype none

module mml_div
    import mml_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [NUM_W-1:0] div_reg, div_next;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   diff;

    // One restoring step: shift in the next dividend bit, try to subtract.
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[NUM_W]) begin
                rem_next = diff[NUM_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[NUM_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### tb/tb_mml_note_stream_parser.sv
// Self-checking testbench for the music macro text parser: directed text, then
// random note, rest and octave words, scored against a behavioral parser model.
// Depends on mml_pkg and the mml_note_stream_parser RTL.
module tb_mml_note_stream_parser
    import mml_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_PCT = 28;

    // One event as it leaves the block.
    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  note;
        logic [21:0] pitch;
        logic [15:0] div;
        logic [15:0] dur;
        logic [7:0]  ch;
        logic        last;
    } mml_event_t;

    // One row of directed text; typed rows carry their single expected event.
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        logic [1:0]  kind;
        logic [15:0] div;
        logic [15:0] dur;
    } text_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Parser model state and its copy of the registers.
    logic [2:0]   octave_now;
    parse_phase_t phase_now;
    logic         rest_open;
    logic [6:0]   note_open;
    logic [15:0]  length_acc;
    logic         length_seen;
    logic [15:0]  beat_ms_cfg;
    logic [15:0]  warn_ms_cfg;

    // Lowest octave tone frequencies, Hz in Q16, c up to b.
    logic [22:0] tone_base [0:11] = '{
        23'd4286054, 23'd4540917, 23'd4810933, 23'd5097006, 23'd5400090, 23'd5721196,
        23'd6061396, 23'd6421826, 23'd6803688, 23'd7208255, 23'd7636881, 23'd8090993
    };

    mml_event_t fresh_events [$];
    mml_event_t events_due [$];
    mml_event_t got_event;
    mml_event_t typed_event;
    text_row_t  text_plan [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  stall_cycles = 0;
    bit  no_gaps = 1'b0;
    bit  hold_req = 1'b0;

    mml_note_stream_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Frequency of a semitone index in Hz Q8, rounded and saturated to 22 bits.
    function automatic logic [21:0] tone_q8(input logic [6:0] idx);
        int          oct;
        int          semi;
        logic [63:0] v;
        oct = idx / 12;
        semi = idx % 12;
        v = ((64'(tone_base[semi]) << oct) + 64'd128) >> 8;
        if (v > 64'h3FFFFF) begin
            v = 64'h3FFFFF;
        end
        return v[21:0];
    endfunction

    function automatic logic [3:0] letter_semitone(input logic [7:0] ch);
        logic [3:0] off;
        case (ch | 8'h20)
            "a":     off = 4'd9;
            "b":     off = 4'd11;
            "d":     off = 4'd2;
            "e":     off = 4'd4;
            "f":     off = 4'd5;
            "g":     off = 4'd7;
            default: off = 4'd0;
        endcase
        return off;
    endfunction

    function automatic void reset_parser();
        octave_now = 3'd2;
        phase_now = PH_IDLE;
        rest_open = 1'b0;
        note_open = 7'd0;
        length_acc = 16'd0;
        length_seen = 1'b0;
        beat_ms_cfg = 16'd600;
        warn_ms_cfg = 16'd500;
    endfunction

    // Emit the pending note or rest and return to idle.
    function automatic void close_pending();
        mml_event_t ev;
        logic [15:0] d;
        d = (length_seen && length_acc != 16'd0) ? length_acc : 16'd1;
        ev.kind = rest_open ? EV_REST : EV_NOTE;
        ev.note = rest_open ? 7'd0 : note_open;
        ev.pitch = rest_open ? 22'd0 : tone_q8(note_open);
        ev.div = d;
        ev.dur = beat_ms_cfg / d;
        ev.ch = 8'd0;
        ev.last = 1'b0;
        fresh_events.push_back(ev);
        phase_now = PH_IDLE;
        rest_open = 1'b0;
        note_open = 7'd0;
        length_acc = 16'd0;
        length_seen = 1'b0;
    endfunction

    // Advance the parser by one text beat; new events land in fresh_events.
    function automatic void parse_text(input logic [7:0] ch, input logic fin);
        mml_event_t  ev;
        int unsigned acc;
        if (fin) begin
            if (phase_now != PH_IDLE) begin
                close_pending();
            end
        end else if (phase_now == PH_DETUNE && (ch == CH_PLUS || ch == CH_MINUS)) begin
            if (ch == CH_PLUS && note_open < NOTE_MAX) begin
                note_open = note_open + 7'd1;
            end else if (ch == CH_MINUS && note_open > 7'd0) begin
                note_open = note_open - 7'd1;
            end
        end else if (phase_now != PH_IDLE && ch >= CH_ZERO && ch <= CH_NINE) begin
            acc = length_acc * 10 + (ch - CH_ZERO);
            length_acc = (acc > 65535) ? 16'hFFFF : acc[15:0];
            length_seen = 1'b1;
            phase_now = PH_DIGITS;
        end else begin
            // A byte that cannot extend the pending event closes it first.
            if (phase_now != PH_IDLE) begin
                close_pending();
            end
            if (ch == CH_SPACE || ch == CH_CR || ch == CH_LF) begin
                // Blanks are skipped.
            end else if (ch == CH_GT) begin
                if (octave_now < 3'(OCTAVES - 1)) begin
                    octave_now = octave_now + 3'd1;
                end
            end else if (ch == CH_LT) begin
                if (octave_now > 3'd0) begin
                    octave_now = octave_now - 3'd1;
                end
            end else if ((ch >= CH_LA && ch <= CH_LG) || (ch >= CH_UA && ch <= CH_UG)) begin
                note_open = 7'(12 * octave_now + letter_semitone(ch));
                rest_open = 1'b0;
                length_acc = 16'd0;
                length_seen = 1'b0;
                phase_now = PH_DETUNE;
            end else if (ch == CH_LR || ch == CH_UR) begin
                note_open = 7'd0;
                rest_open = 1'b1;
                length_acc = 16'd0;
                length_seen = 1'b0;
                phase_now = PH_DIGITS;
            end else begin
                ev.kind = EV_WARN;
                ev.note = 7'd0;
                ev.pitch = 22'd0;
                ev.div = 16'd1;
                ev.dur = warn_ms_cfg;
                ev.ch = ch;
                ev.last = 1'b0;
                fresh_events.push_back(ev);
            end
        end
        if (fresh_events.size() > 0) begin
            ev = fresh_events.pop_back();
            ev.last = 1'b1;
            fresh_events.push_back(ev);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 50) begin
            $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Offer one text beat after a random gap and wait for it to be taken.
    task automatic send_text(input logic [7:0] ch, input logic fin, input bit use_model);
        int gap;
        gap = 0;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= fin;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        items_sent++;
        parse_text(ch, fin);
        if (use_model) begin
            events_due = {events_due, fresh_events};
        end
        fresh_events.delete();
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_text(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0, 1'b1);
    endtask

    // One random word: mostly well-formed notes and rests, plus noise.
    task automatic send_word();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_text(8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + $urandom_range(0, 6)),
                      1'b0, 1'b1);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            repeat (n) send_text($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0, 1'b1);
            send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
                                                     : $urandom_range(0, 2));
        end else if (pick < 55) begin
            send_text($urandom_range(0, 1) ? CH_UR : CH_LR, 1'b0, 1'b1);
            send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
                                                     : $urandom_range(0, 2));
        end else if (pick < 70) begin
            n = $urandom_range(1, 4);
            repeat (n) send_text($urandom_range(0, 1) ? CH_GT : CH_LT, 1'b0, 1'b1);
        end else if (pick < 78) begin
            n = $urandom_range(0, 2);
            send_text((n == 0) ? CH_SPACE : (n == 1) ? CH_CR : CH_LF, 1'b0, 1'b1);
        end else if (pick < 88) begin
            send_text(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end else if (pick < 94) begin
            send_text($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0, 1'b1);
        end else begin
            send_text(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Stop offering and let every due event arrive before the block goes quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (events_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [15:0] beat, input logic [15:0] pause);
        cfg_we <= 1'b1;
        cfg_index <= REG_BEAT_MS;
        cfg_wdata <= beat;
        @(posedge aclk);
        cfg_index <= REG_WARN_PAUSE;
        cfg_wdata <= pause;
        @(posedge aclk);
        cfg_we <= 1'b0;
        beat_ms_cfg = beat;
        warn_ms_cfg = pause;
    endtask

    function automatic void plan_row(input logic [7:0] ch, input logic fin, input logic typed,
                                     input logic [1:0] kind, input logic [15:0] div,
                                     input logic [15:0] dur);
        text_row_t r;
        r.ch = ch;
        r.fin = fin;
        r.typed = typed;
        r.kind = kind;
        r.div = div;
        r.dur = dur;
        text_plan.push_back(r);
    endfunction

    // Directed text at reset settings: end with nothing pending, byte extremes,
    // detune and digit saturation, zero divider, signs after digits and after a
    // rest, octave floor and blanks that close a note.
    function automatic void build_plan();
        plan_row(8'h00, 1'b1, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(8'hFF, 1'b0, 1'b1, EV_WARN, 16'd1, 16'd500);
        plan_row("c", 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_PLUS, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_MINUS, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        repeat (5) plan_row("9", 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_PLUS, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row("R", 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row("0", 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(8'h00, 1'b1, 1'b1, EV_REST, 16'd1, 16'd600);
        plan_row("r", 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_MINUS, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        repeat (3) plan_row(CH_LT, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row("C", 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_MINUS, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_SPACE, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_CR, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(CH_LF, 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row("G", 1'b0, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(8'hA5, 1'b1, 1'b0, EV_NOTE, 16'd0, 16'd0);
        plan_row(8'h00, 1'b0, 1'b1, EV_WARN, 16'd1, 16'd500);
    endfunction

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Score each result beat against the oldest due event.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (events_due.size() == 0) begin
                flag_mismatch("event with none due, kind", m_tuser, 0);
            end else begin
                got_event = events_due.pop_front();
                if (m_tuser != got_event.kind)
                    flag_mismatch("event_kind", m_tuser, got_event.kind);
                if (m_tdata[6:0] != got_event.note)
                    flag_mismatch("note_index", m_tdata[6:0], got_event.note);
                if (m_tdata[28:7] != got_event.pitch)
                    flag_mismatch("pitch_q8", m_tdata[28:7], got_event.pitch);
                if (m_tdata[44:29] != got_event.div)
                    flag_mismatch("length_divider", m_tdata[44:29], got_event.div);
                if (m_tdata[60:45] != got_event.dur)
                    flag_mismatch("duration_ms", m_tdata[60:45], got_event.dur);
                if (m_tdata[68:61] != got_event.ch)
                    flag_mismatch("unknown_char", m_tdata[68:61], got_event.ch);
                if (m_tlast != got_event.last)
                    flag_mismatch("last_of_run", m_tlast, got_event.last);
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Main sequence: reset, directed text, then random phases under new settings.
    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_BEAT_MS;
        cfg_wdata <= 16'd0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'd0;
        s_tlast <= 1'b0;
        reset_parser();
        build_plan();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (text_plan[i]) begin
            send_text(text_plan[i].ch, text_plan[i].fin, !text_plan[i].typed);
            if (text_plan[i].typed) begin
                typed_event.kind = text_plan[i].kind;
                typed_event.note = 7'd0;
                typed_event.pitch = 22'd0;
                typed_event.div = text_plan[i].div;
                typed_event.dur = text_plan[i].dur;
                typed_event.ch = (text_plan[i].kind == EV_WARN) ? text_plan[i].ch : 8'd0;
                typed_event.last = 1'b1;
                events_due.push_back(typed_event);
            end
        end

        for (int p = 1; p <= 7; p++) begin
            drain();
            case (p)
                1:       set_regs(16'd1, 16'd0);
                2:       set_regs(16'hFFFF, 16'hFFFF);
                3:       set_regs(16'd0, 16'($urandom_range(0, 65535)));
                5:       set_regs(16'd500, 16'd100);
                default: set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
            endcase
            no_gaps = (p == 2);
            if (p == 4) begin
                hold_req = 1'b1;
            end
            while (items_sent < text_plan.size() + p * PHASE_ITEMS) begin
                send_word();
            end
        end
        drain();

        if (events_due.size() != 0) begin
            flag_mismatch("events left over", events_due.size(), 0);
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
